>>> design/lpfs_pkg.sv
// Shared types and constants for the lidar potential-field steering block.
package lpfs_pkg;

    // Configuration port geometry and register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_TAN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE  = 3'd5;

    // Register widths
    localparam int unsigned RANGE_W = 15;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned STOP_W  = 32;
    localparam int unsigned TAN_W   = 16;
    localparam int unsigned RATE_W  = 15;
    localparam int unsigned ANG_W   = 16;

    // Register values after reset
    localparam logic [RANGE_W-1:0] RST_MIN_RANGE  = 15'd819;
    localparam logic [RANGE_W-1:0] RST_MAX_RANGE  = 15'd4096;
    localparam logic [GAIN_W-1:0]  RST_GAIN       = 16'd1049;
    localparam logic [STOP_W-1:0]  RST_STOP_LEVEL = 32'd838861;
    localparam logic [TAN_W-1:0]   RST_ALIGN_TAN  = 16'd13284;
    localparam logic [RATE_W-1:0]  RST_TURN_RATE  = 15'd1638;

    // Force numerator scale: gain * |coord| * 2^16
    localparam int unsigned NUM_SHIFT = 16;

    // Steer command codes
    typedef enum logic [1:0] {
        STEER_STOP     = 2'd0,
        STEER_STRAIGHT = 2'd1,
        STEER_TURN_POS = 2'd2,
        STEER_TURN_NEG = 2'd3
    } t_steer;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_MIN,
        ST_MAX,
        ST_CHK,
        ST_NUMX,
        ST_DIVX,
        ST_ACCX,
        ST_DIVY,
        ST_ACCY,
        ST_ABS,
        ST_SQA,
        ST_SQB,
        ST_SQS,
        ST_TLO,
        ST_THI,
        ST_DEC
    } t_state;

    // Operand pairs fed to the shared multiplier
    typedef enum logic [3:0] {
        MS_NONE,
        MS_MX_MX,
        MS_MY_MY,
        MS_MIN_MIN,
        MS_MAX_MAX,
        MS_GAIN_MX,
        MS_GAIN_MY,
        MS_AX_AX,
        MS_AY_AY,
        MS_STOP_STOP,
        MS_TAN_AXLO,
        MS_TAN_AXHI
    } t_msel;

endpackage

>>> design/lidar_potential_field_steer.sv
// Top level: lidar potential-field steering with a shared multiplier and radix-4 divider.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_x, i_y, i_last
//   out     | output    | o_out_valid / i_out_stall  | o_force_x/y, o_steer, o_linear_x/y,
//           |           |                            | o_angular
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A point outside the range window ends after the range check; a kept point also
// passes through the radix-4 divider, which runs once for x and once for y. A last
// point adds the steer decision through the same 32x32 multiplier.
// Reset clears the sequencer, the sums, the output valid and loads register defaults.
// A result waits in the output register while i_out_stall is high; the block holds
// in its decision state until that register frees, and takes no point meanwhile.
module lidar_potential_field_steer #(
    parameter int unsigned COORD_WIDTH = 16,
    parameter int unsigned ACC_WIDTH   = 40
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // point request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_x,
    input  logic signed [COORD_WIDTH-1:0]         i_y,
    input  logic                                  i_last,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ACC_WIDTH-1:0]           o_force_x,
    output logic signed [ACC_WIDTH-1:0]           o_force_y,
    output logic [1:0]                            o_steer,
    output logic signed [ACC_WIDTH-1:0]           o_linear_x,
    output logic signed [ACC_WIDTH-1:0]           o_linear_y,
    output logic signed [lpfs_pkg::ANG_W-1:0]     o_angular,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Derived widths
    localparam int unsigned R2W  = 2 * COORD_WIDTH;                 // squared range
    localparam int unsigned PW   = COORD_WIDTH + lpfs_pkg::GAIN_W;  // gain * |coord|
    localparam int unsigned DW   = PW + lpfs_pkg::NUM_SHIFT;        // dividend
    localparam int unsigned DWE  = DW + (DW % 2);                   // even for radix 4
    localparam int unsigned NSTP = DWE / 2;
    localparam int unsigned CNTW = $clog2(NSTP + 1);
    localparam int unsigned RW   = R2W + 1;
    localparam int unsigned SW   = ((ACC_WIDTH > DWE + 1) ? ACC_WIDTH : DWE + 1) + 1;

    localparam logic signed [SW-1:0] SUM_HI =
        $signed({{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
    localparam logic signed [SW-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [ACC_WIDTH-1:0] ACC_HI = $signed({1'b0, {(ACC_WIDTH - 1){1'b1}}});
    localparam logic signed [ACC_WIDTH-1:0] ACC_LO = ~ACC_HI;

    // Configuration registers
    logic [lpfs_pkg::RANGE_W-1:0] r_min_range;
    logic [lpfs_pkg::RANGE_W-1:0] r_max_range;
    logic [lpfs_pkg::GAIN_W-1:0]  r_gain;
    logic [lpfs_pkg::STOP_W-1:0]  r_stop_level;
    logic [lpfs_pkg::TAN_W-1:0]   r_align_tan;
    logic [lpfs_pkg::RATE_W-1:0]  r_turn_rate;

    // Sequencer and datapath
    lpfs_pkg::t_state r_state, n_state;
    lpfs_pkg::t_msel  w_msel;
    logic             w_div_load;
    logic             w_div_step;
    logic             w_acc;
    logic             w_out_load;
    logic             w_in_acc;
    logic             w_keep;

    logic [COORD_WIDTH-1:0] r_mx, r_my;
    logic                   r_nx, r_ny, r_last;
    logic [R2W-1:0]         r_r2;
    logic                   r_keep_lo;
    logic [63:0]            r_prod;
    logic [31:0]            w_ma, w_mb;
    logic [63:0]            w_prod;

    logic [R2W-1:0]         r_rem, n_rem;
    logic [DWE-1:0]         r_quo, n_quo;
    logic [CNTW-1:0]        r_cnt;
    logic [RW-1:0]          w_sh;

    logic signed [ACC_WIDTH-1:0] r_sum_x, r_sum_y;
    logic signed [ACC_WIDTH-1:0] w_acc_in;
    logic signed [SW-1:0]        w_q, w_term, w_tot;
    logic signed [ACC_WIDTH-1:0] w_sat;
    logic                        w_neg;

    logic [63:0]  r_ax, r_ay;
    logic [ACC_WIDTH-1:0] w_ax, w_ay;
    logic [64:0]  r_ab;
    logic         r_below;
    logic [63:0]  r_tlo;
    logic [95:0]  w_lhs, w_rhs;
    logic         w_window;
    logic         w_stop;
    lpfs_pkg::t_steer w_steer;

    logic                        r_out_valid;
    logic signed [ACC_WIDTH-1:0] r_force_x, r_force_y, r_linear_x, r_linear_y;
    lpfs_pkg::t_steer            r_steer;
    logic signed [lpfs_pkg::ANG_W-1:0] r_angular;
    logic [lpfs_pkg::ANG_W-1:0]  w_rate_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lpfs_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range  <= lpfs_pkg::RST_MIN_RANGE;
            r_max_range  <= lpfs_pkg::RST_MAX_RANGE;
            r_gain       <= lpfs_pkg::RST_GAIN;
            r_stop_level <= lpfs_pkg::RST_STOP_LEVEL;
            r_align_tan  <= lpfs_pkg::RST_ALIGN_TAN;
            r_turn_rate  <= lpfs_pkg::RST_TURN_RATE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lpfs_pkg::CFG_MIN_RANGE:  r_min_range  <= i_cfg_data[lpfs_pkg::RANGE_W-1:0];
                lpfs_pkg::CFG_MAX_RANGE:  r_max_range  <= i_cfg_data[lpfs_pkg::RANGE_W-1:0];
                lpfs_pkg::CFG_GAIN:       r_gain       <= i_cfg_data[lpfs_pkg::GAIN_W-1:0];
                lpfs_pkg::CFG_STOP_LEVEL: r_stop_level <= i_cfg_data[lpfs_pkg::STOP_W-1:0];
                lpfs_pkg::CFG_ALIGN_TAN:  r_align_tan  <= i_cfg_data[lpfs_pkg::TAN_W-1:0];
                lpfs_pkg::CFG_TURN_RATE:  r_turn_rate  <= i_cfg_data[lpfs_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Keep the point when min^2 < r2 < max^2 (max^2 sits in r_prod during the check)
    assign w_keep = r_keep_lo && (64'(r_r2) < r_prod);

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpfs_pkg::ST_IDLE: if (w_in_acc) n_state = lpfs_pkg::ST_SQX;
            lpfs_pkg::ST_SQX:  n_state = lpfs_pkg::ST_SQY;
            lpfs_pkg::ST_SQY:  n_state = lpfs_pkg::ST_MIN;
            lpfs_pkg::ST_MIN:  n_state = lpfs_pkg::ST_MAX;
            lpfs_pkg::ST_MAX:  n_state = lpfs_pkg::ST_CHK;
            lpfs_pkg::ST_CHK: begin
                if (w_keep)      n_state = lpfs_pkg::ST_NUMX;
                else if (r_last) n_state = lpfs_pkg::ST_ABS;
                else             n_state = lpfs_pkg::ST_IDLE;
            end
            lpfs_pkg::ST_NUMX: n_state = lpfs_pkg::ST_DIVX;
            lpfs_pkg::ST_DIVX: if (r_cnt == CNTW'(1)) n_state = lpfs_pkg::ST_ACCX;
            lpfs_pkg::ST_ACCX: n_state = lpfs_pkg::ST_DIVY;
            lpfs_pkg::ST_DIVY: if (r_cnt == CNTW'(1)) n_state = lpfs_pkg::ST_ACCY;
            lpfs_pkg::ST_ACCY: n_state = r_last ? lpfs_pkg::ST_ABS : lpfs_pkg::ST_IDLE;
            lpfs_pkg::ST_ABS:  n_state = lpfs_pkg::ST_SQA;
            lpfs_pkg::ST_SQA:  n_state = lpfs_pkg::ST_SQB;
            lpfs_pkg::ST_SQB:  n_state = lpfs_pkg::ST_SQS;
            lpfs_pkg::ST_SQS:  n_state = lpfs_pkg::ST_TLO;
            lpfs_pkg::ST_TLO:  n_state = lpfs_pkg::ST_THI;
            lpfs_pkg::ST_THI:  n_state = lpfs_pkg::ST_DEC;
            lpfs_pkg::ST_DEC:  if (w_out_load) n_state = lpfs_pkg::ST_IDLE;
            default:           n_state = lpfs_pkg::ST_IDLE;
        endcase
    end

    // Drive datapath controls from the state
    always_comb begin
        w_msel     = lpfs_pkg::MS_NONE;
        w_div_load = 1'b0;
        w_div_step = 1'b0;
        w_acc      = 1'b0;
        case (r_state)
            lpfs_pkg::ST_SQX:  w_msel = lpfs_pkg::MS_MX_MX;
            lpfs_pkg::ST_SQY:  w_msel = lpfs_pkg::MS_MY_MY;
            lpfs_pkg::ST_MIN:  w_msel = lpfs_pkg::MS_MIN_MIN;
            lpfs_pkg::ST_MAX:  w_msel = lpfs_pkg::MS_MAX_MAX;
            lpfs_pkg::ST_CHK:  w_msel = lpfs_pkg::MS_GAIN_MX;
            lpfs_pkg::ST_NUMX: begin
                w_msel     = lpfs_pkg::MS_GAIN_MY;
                w_div_load = 1'b1;
            end
            lpfs_pkg::ST_DIVX: w_div_step = 1'b1;
            lpfs_pkg::ST_ACCX: begin
                w_acc      = 1'b1;
                w_div_load = 1'b1;
            end
            lpfs_pkg::ST_DIVY: w_div_step = 1'b1;
            lpfs_pkg::ST_ACCY: w_acc = 1'b1;
            lpfs_pkg::ST_SQA:  w_msel = lpfs_pkg::MS_AX_AX;
            lpfs_pkg::ST_SQB:  w_msel = lpfs_pkg::MS_AY_AY;
            lpfs_pkg::ST_SQS:  w_msel = lpfs_pkg::MS_STOP_STOP;
            lpfs_pkg::ST_TLO:  w_msel = lpfs_pkg::MS_TAN_AXLO;
            lpfs_pkg::ST_THI:  w_msel = lpfs_pkg::MS_TAN_AXHI;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the point as sign and magnitude
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_nx   <= i_x[COORD_WIDTH-1];
            r_ny   <= i_y[COORD_WIDTH-1];
            r_mx   <= i_x[COORD_WIDTH-1] ? (~$unsigned(i_x) + 1'b1) : $unsigned(i_x);
            r_my   <= i_y[COORD_WIDTH-1] ? (~$unsigned(i_y) + 1'b1) : $unsigned(i_y);
            r_last <= i_last;
        end
    end

    // Select multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (w_msel)
            lpfs_pkg::MS_MX_MX:     begin w_ma = 32'(r_mx);        w_mb = 32'(r_mx);        end
            lpfs_pkg::MS_MY_MY:     begin w_ma = 32'(r_my);        w_mb = 32'(r_my);        end
            lpfs_pkg::MS_MIN_MIN:   begin w_ma = 32'(r_min_range); w_mb = 32'(r_min_range); end
            lpfs_pkg::MS_MAX_MAX:   begin w_ma = 32'(r_max_range); w_mb = 32'(r_max_range); end
            lpfs_pkg::MS_GAIN_MX:   begin w_ma = 32'(r_gain);      w_mb = 32'(r_mx);        end
            lpfs_pkg::MS_GAIN_MY:   begin w_ma = 32'(r_gain);      w_mb = 32'(r_my);        end
            lpfs_pkg::MS_AX_AX:     begin w_ma = r_ax[31:0];       w_mb = r_ax[31:0];       end
            lpfs_pkg::MS_AY_AY:     begin w_ma = r_ay[31:0];       w_mb = r_ay[31:0];       end
            lpfs_pkg::MS_STOP_STOP: begin w_ma = r_stop_level;     w_mb = r_stop_level;     end
            lpfs_pkg::MS_TAN_AXLO:  begin w_ma = 32'(r_align_tan); w_mb = r_ax[31:0];       end
            lpfs_pkg::MS_TAN_AXHI:  begin w_ma = 32'(r_align_tan); w_mb = r_ax[63:32];      end
            default: ;
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);

    // Register each product; hold it when the multiplier is unused
    always_ff @(posedge i_clk) begin
        if (w_msel != lpfs_pkg::MS_NONE) begin
            r_prod <= w_prod;
        end
    end

    // Build r2 and the inner-limit compare from successive products
    always_ff @(posedge i_clk) begin
        case (r_state)
            lpfs_pkg::ST_SQY: r_r2      <= R2W'(r_prod);
            lpfs_pkg::ST_MIN: r_r2      <= r_r2 + R2W'(r_prod);
            lpfs_pkg::ST_MAX: r_keep_lo <= (64'(r_r2) > r_prod);
            default: ;
        endcase
    end

    // Two restoring division steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        w_sh  = '0;
        for (int k = 0; k < 2; k++) begin
            w_sh  = {n_rem, n_quo[DWE-1]};
            n_quo = {n_quo[DWE-2:0], 1'b0};
            if (w_sh >= {1'b0, r_r2}) begin
                w_sh     = w_sh - {1'b0, r_r2};
                n_quo[0] = 1'b1;
            end
            n_rem = w_sh[R2W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_load) begin
            r_quo <= DWE'({r_prod[PW-1:0], {lpfs_pkg::NUM_SHIFT{1'b0}}});
            r_rem <= '0;
        end else if (w_div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_div_load) begin
            r_cnt <= CNTW'(NSTP);
        end else if (w_div_step) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    // Saturating accumulate; the force opposes the coordinate
    assign w_neg    = (r_state == lpfs_pkg::ST_ACCY) ? r_ny : r_nx;
    assign w_acc_in = (r_state == lpfs_pkg::ST_ACCY) ? r_sum_y : r_sum_x;
    assign w_q      = $signed(SW'(r_quo));
    assign w_term   = w_neg ? w_q : -w_q;
    assign w_tot    = SW'(w_acc_in) + w_term;

    always_comb begin
        if (w_tot > SUM_HI) begin
            w_sat = ACC_HI;
        end else if (w_tot < SUM_LO) begin
            w_sat = ACC_LO;
        end else begin
            w_sat = w_tot[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (w_out_load) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (w_acc && r_state == lpfs_pkg::ST_ACCX) begin
            r_sum_x <= w_sat;
        end else if (w_acc) begin
            r_sum_y <= w_sat;
        end
    end

    // Force magnitudes and stop / window terms
    assign w_ax = r_sum_x[ACC_WIDTH-1] ? (~$unsigned(r_sum_x) + 1'b1) : $unsigned(r_sum_x);
    assign w_ay = r_sum_y[ACC_WIDTH-1] ? (~$unsigned(r_sum_y) + 1'b1) : $unsigned(r_sum_y);

    always_ff @(posedge i_clk) begin
        case (r_state)
            lpfs_pkg::ST_ABS: begin
                r_ax <= 64'(w_ax);
                r_ay <= 64'(w_ay);
            end
            lpfs_pkg::ST_SQB: r_ab <= 65'(r_prod);
            lpfs_pkg::ST_SQS: r_ab <= r_ab + 65'(r_prod);
            lpfs_pkg::ST_TLO: r_below <= (r_ab < 65'(r_prod))
                                      && (r_ax < 64'(r_stop_level))
                                      && (r_ay < 64'(r_stop_level));
            lpfs_pkg::ST_THI: r_tlo <= r_prod;
            default: ;
        endcase
    end

    assign w_lhs    = 96'({r_ay, {lpfs_pkg::NUM_SHIFT{1'b0}}});
    assign w_rhs    = {r_prod, 32'b0} + 96'(r_tlo);
    assign w_window = (w_lhs < w_rhs);
    assign w_stop   = r_below || ((r_ax == '0) && (r_ay == '0));

    always_comb begin
        if (w_stop) begin
            w_steer = lpfs_pkg::STEER_STOP;
        end else if (w_window) begin
            w_steer = lpfs_pkg::STEER_STRAIGHT;
        end else if (r_sum_x[ACC_WIDTH-1] != r_sum_y[ACC_WIDTH-1]) begin
            w_steer = lpfs_pkg::STEER_TURN_NEG;
        end else begin
            w_steer = lpfs_pkg::STEER_TURN_POS;
        end
    end

    // Load the result register once it is free
    assign w_out_load = (r_state == lpfs_pkg::ST_DEC) && (!r_out_valid || !i_out_stall);
    assign w_rate_ext = {1'b0, r_turn_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_force_x  <= r_sum_x;
            r_force_y  <= r_sum_y;
            r_steer    <= w_steer;
            r_linear_x <= (w_steer == lpfs_pkg::STEER_STRAIGHT) ? r_sum_x : '0;
            r_linear_y <= (w_steer == lpfs_pkg::STEER_STRAIGHT) ? r_sum_y : '0;
            case (w_steer)
                lpfs_pkg::STEER_TURN_POS: r_angular <= $signed(w_rate_ext);
                lpfs_pkg::STEER_TURN_NEG: r_angular <= $signed(-w_rate_ext);
                default:                  r_angular <= '0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_force_x   = r_force_x;
    assign o_force_y   = r_force_y;
    assign o_steer     = r_steer;
    assign o_linear_x  = r_linear_x;
    assign o_linear_y  = r_linear_y;
    assign o_angular   = r_angular;

    // Check sequencing and result consistency
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("block took a point without going busy");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == lpfs_pkg::ST_DEC))
        else $error("result raised outside the decision step");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_sum_x == '0) && (r_sum_y == '0))
        else $error("sums not cleared after a result");

    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_steer == lpfs_pkg::STEER_STOP) |->
            (o_angular == '0) && (o_linear_x == '0) && (o_linear_y == '0))
        else $error("stop result carries a motion command");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_step |-> (r_cnt != '0))
        else $error("divider stepped with an empty count");

endmodule
